// ----- sv/ttms_pkg.sv -----
`timescale 1ns / 1ps
// Package for the tip-tilt mirror servo: field widths, register indexes,
// fixed-point helpers and the elaboration-time sine and cosine tables.
// No dependencies.
package ttms_pkg;

    localparam int VAL_W  = 24;
    localparam int GAIN_W = 16;
    localparam int PROD_W = VAL_W + GAIN_W;
    localparam int ACC_W  = VAL_W + 2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 104;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAINS_X       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAINS_Y       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FEED_GAINS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_FLUX      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MOD_AMPLITUDE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMITS        = 3'd7;

    localparam int MODE_SINE = 0;
    localparam int MODE_FAKE = 1;
    localparam int MODE_SEND = 2;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam logic signed [GAIN_W-1:0] FAKE_GAIN = 16'sd8192;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint Q30_ONE    = 64'sd1073741824;

    localparam logic signed [ACC_W-1:0] V_MAX = 26'sd8388607;
    localparam logic signed [ACC_W-1:0] V_MIN = -26'sd8388608;

    typedef logic signed [GAIN_W-1:0] sine_table_t [SINE_TABLE_DEPTH];

    function automatic logic signed [ACC_W-1:0] sx26(input logic signed [VAL_W-1:0] v);
        return {{(ACC_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic logic signed [VAL_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > V_MAX) begin
            r = V_MAX[VAL_W-1:0];
        end else if (v < V_MIN) begin
            r = V_MIN[VAL_W-1:0];
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // clamp to +-lim, then to the signed 24-bit range
    function automatic logic signed [VAL_W-1:0] limit_to(input logic signed [ACC_W-1:0] v,
                                                         input logic [VAL_W-1:0] lim);
        logic signed [ACC_W-1:0] l;
        logic signed [ACC_W-1:0] c;
        l = {2'b00, lim};
        c = v;
        if (v > l) begin
            c = l;
        end else if (v < -l) begin
            c = -l;
        end
        return sat24(c);
    endfunction

    // round half up, shift right by 13 or 15, saturate to 24 bits
    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [PROD_W-1:0] p,
                                                          input logic sh15);
        logic signed [PROD_W:0] ps;
        logic signed [27:0] q;
        ps = {p[PROD_W-1], p} + (sh15 ? 41'sd16384 : 41'sd4096);
        q  = sh15 ? 28'(ps >>> 15) : 28'(ps >>> 13);
        if (q > 28'sd8388607) begin
            return V_MAX[VAL_W-1:0];
        end else if (q < -28'sd8388608) begin
            return V_MIN[VAL_W-1:0];
        end
        return q[VAL_W-1:0];
    endfunction

    function automatic longint quarter_sine(input longint f);
        longint r;
        longint r2;
        longint a;
        longint s;
        r  = (f * TWO_PI_Q30 + 64'sd32768) >>> 16;
        r2 = (r * r) >>> 30;
        a  = Q30_ONE - r2 / 72;
        a  = Q30_ONE - ((r2 * a) >>> 30) / 42;
        a  = Q30_ONE - ((r2 * a) >>> 30) / 20;
        a  = Q30_ONE - ((r2 * a) >>> 30) / 6;
        s  = (((r * a) >>> 30) + 64'sd16384) >>> 15;
        return (s > 64'sd32767) ? 64'sd32767 : s;
    endfunction

    function automatic longint sine_turns(input longint t);
        longint q;
        longint f;
        longint s;
        q = (t >>> 14) & 64'sd3;
        f = t & 64'sd16383;
        s = q[0] ? quarter_sine(64'sd16384 - f) : quarter_sine(f);
        return q[1] ? -s : s;
    endfunction

    function automatic sine_table_t build_sine_table(input logic cosine);
        sine_table_t tab;
        longint t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t = ((longint'(i) << 16) / SINE_TABLE_DEPTH) & 64'sd65535;
            if (cosine) begin
                t = (t + 64'sd16384) & 64'sd65535;
            end
            tab[i] = GAIN_W'(sine_turns(t));
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table(1'b0);
    localparam sine_table_t COS_TABLE  = build_sine_table(1'b1);

endpackage

// ----- sv/tip_tilt_mirror_servo.sv -----
`timescale 1ns / 1ps
// Top level of the tip-tilt mirror servo: sequencer around one shared
// 16x24 multiplier, configuration registers and the result register.
// Depends on ttms_pkg.

// One frame beat in, one result beat out. Each frame runs through one shared
// signed 16x24 multiplier, each product passing the multiply, round and
// saturate, and accumulate steps, followed by step clamp, correction update
// and result load. A frame takes N products, with N = 2 in fake-mirror mode
// plus 2 in sine mode or 6 with the servo running (0 when tripped or off).
// s_tready is high only between frames; a finished result waits in its own
// register, so the next frame is taken while it is still pending.
// Configuration writes belong to idle periods.
module tip_tilt_mirror_servo (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ttms_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ttms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // error_x, error_y, mean_flux, feed_az, feed_el, start_servo, zero pad
    input  logic [ttms_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // correct_x, correct_y, adjusted_error_x, adjusted_error_y,
    // servo_active, tripped, send_now, zero pad
    output logic [ttms_pkg::M_TDATA_W-1:0]       m_tdata
);
    import ttms_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_STEP = 3'd4;
    localparam logic [2:0] ST_CORR = 3'd5;
    localparam logic [2:0] ST_PUSH = 3'd6;

    localparam logic [3:0] OP_FAKE_X = 4'd0;
    localparam logic [3:0] OP_FAKE_Y = 4'd1;
    localparam logic [3:0] OP_SIN_X  = 4'd2;
    localparam logic [3:0] OP_SIN_Y  = 4'd3;
    localparam logic [3:0] OP_GX     = 4'd4;
    localparam logic [3:0] OP_FX     = 4'd5;
    localparam logic [3:0] OP_DX     = 4'd6;
    localparam logic [3:0] OP_GY     = 4'd7;
    localparam logic [3:0] OP_FY     = 4'd8;
    localparam logic [3:0] OP_DY     = 4'd9;

    logic [2:0]  mode_reg;
    logic [31:0] gains_x_reg;
    logic [31:0] gains_y_reg;
    logic [31:0] feed_gains_reg;
    logic [31:0] min_flux_reg;
    logic [47:0] mod_amp_reg;
    logic [15:0] phase_step_reg;
    logic [47:0] limits_reg;

    logic [2:0] state_reg, state_next;
    logic [3:0] op_reg, op_next;

    logic signed [VAL_W-1:0]  adj_x_reg, adj_x_next;
    logic signed [VAL_W-1:0]  adj_y_reg, adj_y_next;
    logic signed [VAL_W-1:0]  feed_az_reg, feed_az_next;
    logic signed [VAL_W-1:0]  feed_el_reg, feed_el_next;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0]  acc_y_reg, acc_y_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [VAL_W-1:0]  term_reg, term_next;

    logic signed [VAL_W-1:0] mirror_x_reg, mirror_x_next;
    logic signed [VAL_W-1:0] mirror_y_reg, mirror_y_next;
    logic signed [VAL_W-1:0] last_x_reg, last_x_next;
    logic signed [VAL_W-1:0] last_y_reg, last_y_next;
    logic [15:0]             mod_phase_reg, mod_phase_next;
    logic                    servo_on_reg, servo_on_next;
    logic                    trip_reg, trip_next;
    logic                    zero_reg, zero_next;
    logic                    run_reg, run_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic signed [GAIN_W-1:0] op_a;
    logic signed [VAL_W-1:0]  op_b;
    logic [31:0]              phase_prod;
    logic [IDX_W-1:0]         sine_idx;
    logic                     sine_op;
    logic                     servo_eff;
    logic                     low_flux;
    logic                     trip_now;
    logic signed [ACC_W-1:0]  base_x, base_y;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign phase_prod = 32'(mod_phase_reg) * 32'(SINE_TABLE_DEPTH);
    assign sine_idx   = phase_prod[16 +: IDX_W];
    assign sine_op    = (op_reg == OP_SIN_X) || (op_reg == OP_SIN_Y);

    assign servo_eff = servo_on_reg | s_tdata[128];
    assign low_flux  = (s_tdata[79:48] < min_flux_reg);
    assign trip_now  = !mode_reg[MODE_SINE] && servo_eff && low_flux;

    assign base_x = zero_reg ? '0 : sx26(mirror_x_reg);
    assign base_y = zero_reg ? '0 : sx26(mirror_y_reg);

    always_comb begin
        case (op_reg)
            OP_FAKE_X: begin op_a = FAKE_GAIN;               op_b = mirror_x_reg; end
            OP_FAKE_Y: begin op_a = FAKE_GAIN;               op_b = mirror_y_reg; end
            OP_SIN_X:  begin op_a = SINE_TABLE[sine_idx];    op_b = mod_amp_reg[23:0]; end
            OP_SIN_Y:  begin op_a = COS_TABLE[sine_idx];     op_b = mod_amp_reg[47:24]; end
            OP_GX:     begin op_a = gains_x_reg[15:0];       op_b = adj_x_reg; end
            OP_FX:     begin op_a = feed_gains_reg[15:0];    op_b = feed_az_reg; end
            OP_DX:     begin op_a = gains_x_reg[31:16];      op_b = last_x_reg; end
            OP_GY:     begin op_a = gains_y_reg[15:0];       op_b = adj_y_reg; end
            OP_FY:     begin op_a = feed_gains_reg[31:16];   op_b = feed_el_reg; end
            OP_DY:     begin op_a = gains_y_reg[31:16];      op_b = last_y_reg; end
            default:   begin op_a = '0;                      op_b = '0; end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        adj_x_next     = adj_x_reg;
        adj_y_next     = adj_y_reg;
        feed_az_next   = feed_az_reg;
        feed_el_next   = feed_el_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        prod_next      = prod_reg;
        term_next      = term_reg;
        mirror_x_next  = mirror_x_reg;
        mirror_y_next  = mirror_y_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        mod_phase_next = mod_phase_reg;
        servo_on_next  = servo_on_reg;
        trip_next      = trip_reg;
        zero_next      = zero_reg;
        run_next       = run_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    adj_x_next    = s_tdata[23:0];
                    adj_y_next    = s_tdata[47:24];
                    feed_az_next  = s_tdata[103:80];
                    feed_el_next  = s_tdata[127:104];
                    acc_x_next    = '0;
                    acc_y_next    = '0;
                    servo_on_next = servo_eff & ~trip_now;
                    trip_next     = trip_now;
                    zero_next     = !mode_reg[MODE_SINE] && !(servo_eff && !trip_now);
                    run_next      = !mode_reg[MODE_SINE] && servo_eff && !trip_now;
                    if (mode_reg[MODE_FAKE]) begin
                        op_next    = OP_FAKE_X;
                        state_next = ST_MUL;
                    end else if (mode_reg[MODE_SINE]) begin
                        op_next    = OP_SIN_X;
                        state_next = ST_MUL;
                    end else if (servo_eff && !trip_now) begin
                        op_next    = OP_GX;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(op_a) * PROD_W'(op_b);
                state_next = ST_RND;
            end
            ST_RND: begin
                term_next  = round_sat(prod_reg, sine_op);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = ST_MUL;
                case (op_reg)
                    OP_FAKE_X: begin
                        adj_x_next = sat24(sx26(adj_x_reg) - sx26(term_reg));
                        op_next    = OP_FAKE_Y;
                    end
                    OP_FAKE_Y: begin
                        adj_y_next = sat24(sx26(adj_y_reg) - sx26(term_reg));
                        if (mode_reg[MODE_SINE]) begin
                            op_next = OP_SIN_X;
                        end else if (run_reg) begin
                            op_next = OP_GX;
                        end else begin
                            state_next = ST_STEP;
                        end
                    end
                    OP_SIN_X: begin
                        acc_x_next = sx26(term_reg) - sx26(mirror_x_reg);
                        op_next    = OP_SIN_Y;
                    end
                    OP_SIN_Y: begin
                        acc_y_next     = sx26(term_reg) - sx26(mirror_y_reg);
                        mod_phase_next = mod_phase_reg + phase_step_reg;
                        state_next     = ST_STEP;
                    end
                    OP_GX: begin
                        acc_x_next = sx26(term_reg);
                        op_next    = OP_FX;
                    end
                    OP_FX: begin
                        acc_x_next = acc_x_reg + sx26(term_reg);
                        op_next    = OP_DX;
                    end
                    OP_DX: begin
                        acc_x_next = acc_x_reg - sx26(term_reg);
                        op_next    = OP_GY;
                    end
                    OP_GY: begin
                        acc_y_next = sx26(term_reg);
                        op_next    = OP_FY;
                    end
                    OP_FY: begin
                        acc_y_next = acc_y_reg + sx26(term_reg);
                        op_next    = OP_DY;
                    end
                    OP_DY: begin
                        acc_y_next = acc_y_reg - sx26(term_reg);
                        state_next = ST_STEP;
                    end
                    default: begin
                        state_next = ST_STEP;
                    end
                endcase
            end
            ST_STEP: begin
                last_x_next = limit_to(sx26(sat24(acc_x_reg)), limits_reg[47:24]);
                last_y_next = limit_to(sx26(sat24(acc_y_reg)), limits_reg[47:24]);
                state_next  = ST_CORR;
            end
            ST_CORR: begin
                mirror_x_next = limit_to(base_x + sx26(last_x_reg), limits_reg[23:0]);
                mirror_y_next = limit_to(base_y + sx26(last_y_reg), limits_reg[23:0]);
                state_next    = ST_PUSH;
            end
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {5'b0, mode_reg[MODE_SEND], trip_reg, servo_on_reg,
                                     adj_y_reg, adj_x_reg, mirror_y_reg, mirror_x_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= '0;
            gains_x_reg    <= '0;
            gains_y_reg    <= '0;
            feed_gains_reg <= '0;
            min_flux_reg   <= '0;
            mod_amp_reg    <= '0;
            phase_step_reg <= '0;
            limits_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MODE:          mode_reg       <= cfg_wdata[2:0];
                REG_GAINS_X:       gains_x_reg    <= cfg_wdata[31:0];
                REG_GAINS_Y:       gains_y_reg    <= cfg_wdata[31:0];
                REG_FEED_GAINS:    feed_gains_reg <= cfg_wdata[31:0];
                REG_MIN_FLUX:      min_flux_reg   <= cfg_wdata[31:0];
                REG_MOD_AMPLITUDE: mod_amp_reg    <= cfg_wdata[47:0];
                REG_PHASE_STEP:    phase_step_reg <= cfg_wdata[15:0];
                REG_LIMITS:        limits_reg     <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_FAKE_X;
            mirror_x_reg  <= '0;
            mirror_y_reg  <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            mod_phase_reg <= '0;
            servo_on_reg  <= 1'b0;
            trip_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            run_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            mirror_x_reg  <= mirror_x_next;
            mirror_y_reg  <= mirror_y_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            mod_phase_reg <= mod_phase_next;
            servo_on_reg  <= servo_on_next;
            trip_reg      <= trip_next;
            zero_reg      <= zero_next;
            run_reg       <= run_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        adj_x_reg    <= adj_x_next;
        adj_y_reg    <= adj_y_next;
        feed_az_reg  <= feed_az_next;
        feed_el_reg  <= feed_el_next;
        acc_x_reg    <= acc_x_next;
        acc_y_reg    <= acc_y_next;
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        m_tdata_reg  <= m_tdata_next;
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("frame accepted but sequencer stayed idle");

    a_zero_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && zero_reg) |-> (mirror_x_reg == '0 && mirror_y_reg == '0))
        else $error("correction not cleared with servo off");

    a_corr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |->
            (sx26(mirror_x_reg) <= $signed({2'b00, limits_reg[23:0]}) &&
             sx26(mirror_x_reg) >= -$signed({2'b00, limits_reg[23:0]})))
        else $error("x correction beyond maximum range");

    a_trip_stops_servo: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[97]) |-> !m_tdata[96])
        else $error("trip reported with servo still active");

endmodule
